@@ sv/utse_pkg.sv @@
// ----------------------------------------------------------------------------
// utse_pkg
// Types, character codes, field limits and calendar constants shared by the
// timestamp parser, the epoch conversion pipeline and the checker.
// ----------------------------------------------------------------------------
`default_nettype none

package utse_pkg;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_CHAR   = 2'd2,
    ERR_RANGE  = 2'd3
  } err_t;

  // Accumulated fields of one timestamp together with its verdict.
  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    err_t        err;
  } fields_t;

  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_Z     = 8'h5A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Character positions of the separators in YYYY-MM-DDTHH:MM:SSZ.
  localparam logic [4:0] POS_YEAR_DASH  = 5'd4;
  localparam logic [4:0] POS_MONTH_DASH = 5'd7;
  localparam logic [4:0] POS_DATE_T     = 5'd10;
  localparam logic [4:0] POS_HOUR_COLON = 5'd13;
  localparam logic [4:0] POS_MIN_COLON  = 5'd16;
  localparam logic [4:0] POS_ZULU       = 5'd19;
  localparam logic [4:0] TS_LENGTH      = 5'd20;
  localparam logic [4:0] POS_SATURATE   = 5'd21;

  localparam logic [6:0] MONTH_MAX  = 7'd12;
  localparam logic [6:0] DAY_MAX    = 7'd31;
  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MINSEC_MAX = 7'd59;

  // The year is shifted up by one era so that the March-based year is never
  // negative; the era's days come back out through DAY_BIAS.
  localparam logic [13:0] YEAR_OFFSET   = 14'd400;
  // floor(q / 25) == (q * RECIP_25) >> 16 for every q below 2600.
  localparam logic [11:0] RECIP_25      = 12'd2622;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  // 146097 days for the offset era plus 719468 days from 0000-03-01 to 1970.
  localparam logic [19:0] DAY_BIAS      = 20'd865565;
  localparam logic [16:0] DAY_SECONDS   = 17'd86400;
  localparam logic [11:0] HOUR_SECONDS  = 12'd3600;
  localparam logic [5:0]  MIN_SECONDS   = 6'd60;

  localparam logic signed [38:0] EPOCH_MIN = -39'sd62167219200;
  localparam logic signed [38:0] EPOCH_MAX = 39'sd253402300799;

  // Day of the March-based year on which month index mp (March = 0) starts.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] start;
    case (mp)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd61;
      4'd3:    start = 9'd92;
      4'd4:    start = 9'd122;
      4'd5:    start = 9'd153;
      4'd6:    start = 9'd184;
      4'd7:    start = 9'd214;
      4'd8:    start = 9'd245;
      4'd9:    start = 9'd275;
      4'd10:   start = 9'd306;
      4'd11:   start = 9'd337;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

`default_nettype wire

@@ sv/utse_epoch_calc.sv @@
// ----------------------------------------------------------------------------
// utse_epoch_calc
// Four-stage pipeline that turns a parsed year, month, day and time of day
// into Unix epoch seconds, with a valid bit per stage and bubble collapsing.
// ----------------------------------------------------------------------------
`default_nettype none

module utse_epoch_calc (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_ready,
  input  wire utse_pkg::fields_t     req_fields,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output utse_pkg::err_t             err_code,
  output logic signed [38:0]         epoch_seconds
);

  // Stage a: captured fields.
  logic              a_valid;
  utse_pkg::fields_t a_fields;

  // Stage b: shifted year, quarter year, century count, day of year, seconds
  // of the day.
  logic              b_valid;
  logic [13:0]       b_yp;
  logic [11:0]       b_q;
  logic [7:0]        b_h;
  logic [8:0]        b_doy;
  logic [18:0]       b_tod;
  utse_pkg::err_t    b_err;

  // Stage c: day count from the epoch.
  logic              c_valid;
  logic signed [23:0] c_days;
  logic [18:0]       c_tod;
  utse_pkg::err_t    c_err;

  // Stage d: result register.
  logic              d_valid;
  logic signed [38:0] d_epoch;
  utse_pkg::err_t    d_err;

  logic a_free, b_free, c_free, d_free;

  assign d_free    = !d_valid || out_ready;
  assign c_free    = !c_valid || d_free;
  assign b_free    = !b_valid || c_free;
  assign a_free    = !a_valid || b_free;
  assign req_ready = a_free;

  // Stage b logic.
  logic        mar_based;
  logic [13:0] yp_b;
  logic [3:0]  mp_b;
  logic [11:0] q_b;
  logic [23:0] q_prod_b;
  logic [8:0]  doy_b;
  logic [18:0] tod_b;

  always_comb begin
    mar_based = a_fields.month <= 7'd2;
    yp_b      = a_fields.year + utse_pkg::YEAR_OFFSET - {13'd0, mar_based};
    mp_b      = mar_based ? 4'(a_fields.month + 7'd9) : 4'(a_fields.month - 7'd3);
    q_b       = yp_b[13:2];
    q_prod_b  = q_b * utse_pkg::RECIP_25;
    doy_b     = utse_pkg::month_start(mp_b) + {2'd0, a_fields.day} - 9'd1;
    tod_b     = 19'(a_fields.hour * utse_pkg::HOUR_SECONDS)
              + 19'(a_fields.minute * utse_pkg::MIN_SECONDS)
              + {12'd0, a_fields.second};
  end

  // Stage c logic: 365 * y + y/4 - y/100 + y/400 + doy, less the bias.
  logic [21:0]        year_days_c;
  logic [21:0]        sum_c;
  logic signed [23:0] days_c;

  always_comb begin
    year_days_c = 22'(b_yp * utse_pkg::DAYS_PER_YEAR);
    sum_c       = year_days_c + {10'd0, b_q} + {16'd0, b_h[7:2]} + {13'd0, b_doy};
    days_c      = $signed({2'b00, sum_c}) - $signed({16'd0, b_h})
                - $signed({4'd0, utse_pkg::DAY_BIAS});
  end

  // Stage d logic.
  logic signed [41:0] secs_d;

  always_comb begin
    secs_d = c_days * $signed({1'b0, utse_pkg::DAY_SECONDS})
           + $signed({23'd0, c_tod});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (a_free) a_valid <= req_valid;
      if (b_free) b_valid <= a_valid;
      if (c_free) c_valid <= b_valid;
      if (d_free) d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free) a_fields <= req_fields;
    if (b_free) begin
      b_yp  <= yp_b;
      b_q   <= q_b;
      b_h   <= q_prod_b[23:16];
      b_doy <= doy_b;
      b_tod <= tod_b;
      b_err <= a_fields.err;
    end
    if (c_free) begin
      c_days <= days_c;
      c_tod  <= b_tod;
      c_err  <= b_err;
    end
    if (d_free) begin
      d_err   <= c_err;
      d_epoch <= (c_err == utse_pkg::ERR_OK) ? secs_d[38:0] : 39'sd0;
    end
  end

  assign out_valid     = d_valid;
  assign err_code      = d_err;
  assign epoch_seconds = d_epoch;

endmodule

`default_nettype wire

@@ sv/utc_timestamp_to_epoch_seconds.sv @@
// ----------------------------------------------------------------------------
// utc_timestamp_to_epoch_seconds
// Parses YYYY-MM-DDTHH:MM:SSZ one byte at a time and reports Unix epoch
// seconds or an error code on the byte marked last.
// ----------------------------------------------------------------------------
//
//   channel  handshake            payload
//   input    in_valid/in_ready    char_in[7:0], is_last
//   output   out_valid/out_ready  err_code[1:0], epoch_seconds[38:0] signed
//
// One byte is taken per cycle while in_ready is high. A result is offered once
// it has passed the field register, the century count and day count registers,
// and the seconds multiply into the result register.
// Up to four results may wait in the pipeline; any byte stalls while the
// first stage is occupied and unable to move.
// Reset clears the parser and all stage valid bits.
`default_nettype none

module utc_timestamp_to_epoch_seconds (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          char_in,
  input  wire logic                is_last,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               err_code,
  output logic signed [38:0]       epoch_seconds
);

  logic [4:0]  char_position;
  logic        bad_char_seen;
  logic [13:0] year_digits;
  logic [6:0]  month_digits, day_digits, hour_digits, minute_digits, second_digits;

  logic [4:0]  char_position_next;
  logic        bad_char_seen_next;
  logic [13:0] year_digits_next;
  logic [6:0]  month_digits_next, day_digits_next, hour_digits_next;
  logic [6:0]  minute_digits_next, second_digits_next;

  logic              calc_ready;
  logic              transfer;
  utse_pkg::fields_t req_fields;
  utse_pkg::err_t    calc_err;

  logic [7:0] want;
  logic [3:0] digit;
  logic       is_digit;
  logic       out_of_range;

  assign in_ready = calc_ready;
  assign transfer = in_valid && in_ready;

  always_comb begin
    char_position_next = char_position;
    bad_char_seen_next = bad_char_seen;
    year_digits_next   = year_digits;
    month_digits_next  = month_digits;
    day_digits_next    = day_digits;
    hour_digits_next   = hour_digits;
    minute_digits_next = minute_digits;
    second_digits_next = second_digits;

    case (char_position)
      utse_pkg::POS_YEAR_DASH, utse_pkg::POS_MONTH_DASH: want = utse_pkg::CHAR_DASH;
      utse_pkg::POS_DATE_T:                              want = utse_pkg::CHAR_T;
      utse_pkg::POS_HOUR_COLON, utse_pkg::POS_MIN_COLON: want = utse_pkg::CHAR_COLON;
      utse_pkg::POS_ZULU:                                want = utse_pkg::CHAR_Z;
      default:                                           want = 8'd0;
    endcase

    is_digit = (char_in >= utse_pkg::CHAR_ZERO) && (char_in <= utse_pkg::CHAR_NINE);
    digit    = 4'(char_in - utse_pkg::CHAR_ZERO);

    // Characters past the twentieth are not checked; the length error covers them.
    if (char_position < utse_pkg::TS_LENGTH) begin
      if (want != 8'd0) begin
        if (char_in != want) bad_char_seen_next = 1'b1;
      end else if (!is_digit) begin
        bad_char_seen_next = 1'b1;
      end else if (char_position < utse_pkg::POS_YEAR_DASH) begin
        year_digits_next = 14'(year_digits * 14'd10 + {10'd0, digit});
      end else if (char_position < utse_pkg::POS_MONTH_DASH) begin
        month_digits_next = 7'(month_digits * 7'd10 + {3'd0, digit});
      end else if (char_position < utse_pkg::POS_DATE_T) begin
        day_digits_next = 7'(day_digits * 7'd10 + {3'd0, digit});
      end else if (char_position < utse_pkg::POS_HOUR_COLON) begin
        hour_digits_next = 7'(hour_digits * 7'd10 + {3'd0, digit});
      end else if (char_position < utse_pkg::POS_MIN_COLON) begin
        minute_digits_next = 7'(minute_digits * 7'd10 + {3'd0, digit});
      end else begin
        second_digits_next = 7'(second_digits * 7'd10 + {3'd0, digit});
      end
    end

    if (char_position < utse_pkg::POS_SATURATE) char_position_next = char_position + 5'd1;

    out_of_range = (month_digits_next < 7'd1) || (month_digits_next > utse_pkg::MONTH_MAX)
                || (day_digits_next < 7'd1) || (day_digits_next > utse_pkg::DAY_MAX)
                || (hour_digits_next > utse_pkg::HOUR_MAX)
                || (minute_digits_next > utse_pkg::MINSEC_MAX)
                || (second_digits_next > utse_pkg::MINSEC_MAX);

    if (char_position_next != utse_pkg::TS_LENGTH) calc_err = utse_pkg::ERR_LENGTH;
    else if (bad_char_seen_next)                   calc_err = utse_pkg::ERR_CHAR;
    else if (out_of_range)                         calc_err = utse_pkg::ERR_RANGE;
    else                                           calc_err = utse_pkg::ERR_OK;

    req_fields.year   = year_digits_next;
    req_fields.month  = month_digits_next;
    req_fields.day    = day_digits_next;
    req_fields.hour   = hour_digits_next;
    req_fields.minute = minute_digits_next;
    req_fields.second = second_digits_next;
    req_fields.err    = calc_err;
  end

  always_ff @(posedge clk) begin
    if (rst || (transfer && is_last)) begin
      char_position <= 5'd0;
      bad_char_seen <= 1'b0;
      year_digits   <= 14'd0;
      month_digits  <= 7'd0;
      day_digits    <= 7'd0;
      hour_digits   <= 7'd0;
      minute_digits <= 7'd0;
      second_digits <= 7'd0;
    end else if (transfer) begin
      char_position <= char_position_next;
      bad_char_seen <= bad_char_seen_next;
      year_digits   <= year_digits_next;
      month_digits  <= month_digits_next;
      day_digits    <= day_digits_next;
      hour_digits   <= hour_digits_next;
      minute_digits <= minute_digits_next;
      second_digits <= second_digits_next;
    end
  end

  utse_pkg::err_t out_err;

  utse_epoch_calc u_calc (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (in_valid && is_last),
    .req_ready     (calc_ready),
    .req_fields    (req_fields),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .err_code      (out_err),
    .epoch_seconds (epoch_seconds)
  );

  assign err_code = out_err;

endmodule

`default_nettype wire

@@ sv/utse_checker.sv @@
// ----------------------------------------------------------------------------
// utse_checker
// Port-level checks on the result channel of the timestamp converter, bound
// to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module utse_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         err_code,
  input wire logic signed [38:0] epoch_seconds
);

  // A failed timestamp never carries a time value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (err_code != utse_pkg::ERR_OK) |-> epoch_seconds == 39'sd0)
    else $error("error result with nonzero epoch_seconds");

  // A good timestamp lands between 0000-01-01 and 9999-12-31T23:59:59.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (err_code == utse_pkg::ERR_OK) |->
      (epoch_seconds >= utse_pkg::EPOCH_MIN) && (epoch_seconds <= utse_pkg::EPOCH_MAX))
    else $error("epoch_seconds outside the four-digit year span");

  // Nothing is offered in the cycle after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result holds until its transfer.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(err_code) && $stable(epoch_seconds))
    else $error("stalled result dropped or changed");

endmodule

bind utc_timestamp_to_epoch_seconds utse_checker u_utse_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .err_code      (err_code),
  .epoch_seconds (epoch_seconds)
);

`default_nettype wire
